// File: rtl/binary_min_heap_queue_defines.svh
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 7;
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] min_key;
    logic [CNT_W-1:0]        count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    ins_start;
    logic    del_start;
    logic    up_rd;
    logic    up_step;
    logic    place;
    logic    dn_load;
    logic    dn_rd;
    logic    dn_step;
    logic    load_out;
    status_e status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_del;
    logic full;
    logic empty;
    logic at_root;
    logic up_less;
    logic no_child;
    logic dn_less;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/bmhq_ctrl.sv
`timescale 1ns / 1ps
module bmhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bmhq_pkg::sts_t  sts_i,
  output bmhq_pkg::cmd_t  cmd_o
);
  import bmhq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_UP_RD  = 3'd2;
  localparam logic [2:0] S_UP_CMP = 3'd3;
  localparam logic [2:0] S_DN_LD  = 3'd4;
  localparam logic [2:0] S_DN_RD  = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  status_e    status_q, status_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          status_d     = ST_OK;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.is_del) begin
          if (sts_i.empty) begin
            status_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            cmd_o.del_start = 1'b1;
            state_d         = S_DN_LD;
          end
        end else begin
          if (sts_i.full) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            cmd_o.ins_start = 1'b1;
            state_d         = S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (sts_i.at_root) begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_less) begin
          cmd_o.up_step = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_DN_LD: begin
        cmd_o.dn_load = 1'b1;
        // last key was the root: nothing to move down
        state_d = sts_i.empty ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        if (sts_i.no_child) begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.dn_rd = 1'b1;
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts_i.dn_less) begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

// File: rtl/bmhq_datapath.sv
`timescale 1ns / 1ps
module bmhq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bmhq_pkg::cmd_t                         cmd_i,
  output bmhq_pkg::sts_t                         sts_o,
  input  bmhq_pkg::req_t                         in_req_i,
  input  logic                                   cfg_we_i,
  input  logic [bmhq_pkg::CAP_W-1:0]             cfg_wdata_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output bmhq_pkg::rsp_t                         out_rsp_o
);
  import bmhq_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (PW > CNT_W) ? PW : CNT_W;

  logic signed [KEY_W-1:0] heap_q [DEPTH];
  logic signed [KEY_W-1:0] rd_a_q, rd_b_q, x_q, x_d, min_q;
  logic                    func_q;
  logic [PW-1:0]           pos_q, pos_d, cnt_q, cnt_d;
  logic [CAP_W-1:0]        cap_q;
  rsp_t                    out_q, rsp_d;
  logic                    out_valid_q;

  logic [PW-1:0]           pos_m1, par_pos, par_m1, cnt_m1, child_pos;
  logic [PW:0]             c_pos, c1_pos, c_m1, cnt_wide;
  logic                    has_right, take_right;
  logic signed [KEY_W-1:0] child_val, wd;
  logic                    we, re_a, re_b;
  logic [AW-1:0]           wa, ra_a, ra_b;
  logic [CW-1:0]           cap_ext, cnt_ext, eff_cap;

  // heap positions are 1-based; entry p-1 holds position p
  assign pos_m1   = pos_q - 1'b1;
  assign par_pos  = pos_q >> 1;
  assign par_m1   = par_pos - 1'b1;
  assign cnt_m1   = cnt_q - 1'b1;
  assign c_pos    = {pos_q, 1'b0};
  assign c1_pos   = {pos_q, 1'b1};
  assign c_m1     = c_pos - 1'b1;
  assign cnt_wide = {1'b0, cnt_q};

  // equal children go right
  assign has_right  = (c1_pos <= cnt_wide);
  assign take_right = has_right && !(rd_a_q < rd_b_q);
  assign child_val  = take_right ? rd_b_q : rd_a_q;
  assign child_pos  = take_right ? c1_pos[PW-1:0] : c_pos[PW-1:0];

  assign cap_ext = CW'(cap_q);
  assign cnt_ext = CW'(cnt_q);
  assign eff_cap = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;

  assign sts_o.is_del   = (func_q == FUNC_DELETE);
  assign sts_o.full     = (cnt_ext >= eff_cap);
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.at_root  = (pos_q == PW'(1));
  assign sts_o.up_less  = (x_q < rd_a_q);
  assign sts_o.no_child = (c_pos > cnt_wide);
  assign sts_o.dn_less  = (x_q < child_val);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // memory port selection
  always_comb begin
    we   = cmd_i.up_step || cmd_i.place || cmd_i.dn_step;
    wa   = pos_m1[AW-1:0];
    wd   = cmd_i.up_step ? rd_a_q : (cmd_i.dn_step ? child_val : x_q);
    re_a = cmd_i.up_rd || cmd_i.del_start || cmd_i.dn_rd;
    if (cmd_i.up_rd) begin
      ra_a = par_m1[AW-1:0];
    end else if (cmd_i.dn_rd) begin
      ra_a = c_m1[AW-1:0];
    end else begin
      ra_a = '0;
    end
    re_b = cmd_i.del_start || cmd_i.dn_rd;
    ra_b = cmd_i.del_start ? cnt_m1[AW-1:0] : c_pos[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_q[wa] <= wd;
    end
    if (re_a) begin
      rd_a_q <= heap_q[ra_a];
    end
    if (re_b) begin
      rd_b_q <= heap_q[ra_b];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    x_d   = x_q;
    if (cmd_i.ins_start) begin
      cnt_d = cnt_q + 1'b1;
      pos_d = cnt_q + 1'b1;
    end
    if (cmd_i.del_start) begin
      cnt_d = cnt_m1;
    end
    if (cmd_i.up_step) begin
      pos_d = par_pos;
    end
    if (cmd_i.dn_load) begin
      pos_d = PW'(1);
      x_d   = rd_b_q;
    end
    if (cmd_i.dn_step) begin
      pos_d = child_pos;
    end
    if (cmd_i.accept) begin
      x_d = in_req_i.key;
    end
  end

  always_comb begin
    rsp_d.status  = cmd_i.status;
    rsp_d.min_key = (cmd_i.status == ST_OK && func_q == FUNC_DELETE) ? min_q : '0;
    rsp_d.count   = cnt_ext[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pos_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (cmd_i.accept) begin
      func_q <= in_req_i.func;
    end
    if (cmd_i.dn_load) begin
      min_q <= rd_a_q;
    end
    if (cmd_i.load_out) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: rtl/binary_min_heap_queue.sv
// Flow: a request is accepted, then checked; a refused one (full insert, empty delete)
// goes straight to its result. An insert climbs toward the root one level per compare;
// a delete-min moves the last key to the root and sinks it. The result then loads.
// Only one request is in work at a time; the next accept comes in the cycle after the
// result loads, and output stalls can hold back that load.
// Reset (async, active low) empties the heap and sets the capacity limit to 64.
`timescale 1ns / 1ps
module binary_min_heap_queue #(
  parameter int DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bmhq_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bmhq_pkg::rsp_t             out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [bmhq_pkg::CAP_W-1:0] cfg_wdata_i
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmhq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: rtl/bmhq_checker.sv
`timescale 1ns / 1ps
`include "binary_min_heap_queue_defines.svh"
module bmhq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bmhq_pkg::rsp_t out_rsp_o
);
  import bmhq_pkg::*;

  `BMHQ_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "result changed while stalled")

  // one request in work at a time
  `BMHQ_ASSERT_NXT(a_one_in_work, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

  `BMHQ_ASSERT_IMP(a_empty_rsp, out_valid_o && out_rsp_o.status == ST_EMPTY, out_rsp_o.count == '0 && out_rsp_o.min_key == '0, "bad empty response")

  `BMHQ_ASSERT_IMP(a_full_rsp, out_valid_o && out_rsp_o.status == ST_FULL, out_rsp_o.min_key == '0, "full response carries a key")

endmodule

bind binary_min_heap_queue bmhq_checker u_checker (.*);
